// File: hdl/ibp_pkg.sv
package ibp_pkg;

   // Fixed field widths of the pick block.
   localparam int ID_W       = 24;
   localparam int ECOUNT_W   = 13;
   localparam int WORD_NUM_W = 6;
   localparam int HIT_W      = 64;
   localparam int BIT_IDX_W  = 6;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Alpha values up to this one mark a pixel with no object.
   localparam logic [7:0] ALPHA_NONE_MAX = 8'd2;

   // Command codes of an input beat.
   localparam logic CMD_PIXEL  = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // Pick modes.
   localparam logic MODE_REGION  = 1'b0;
   localparam logic MODE_NEAREST = 1'b1;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_RECT_X       = 3'd0,
      CSR_RECT_Y       = 3'd1,
      CSR_RECT_W       = 3'd2,
      CSR_RECT_H       = 3'd3,
      CSR_PICK_MODE    = 3'd4,
      CSR_ENTITY_COUNT = 3'd5
   } csr_idx_type;

   // Control from the sequencer to the nearest tracker.
   typedef struct packed {
      logic px_valid;
      logic clear;
   } near_ctl_type;

   // Nearest tracker result as seen by the output stage.
   typedef struct packed {
      logic            found;
      logic [ID_W-1:0] id;
   } near_res_type;

endpackage

// File: hdl/id_buffer_pick.sv
// Channel  | Direction | Handshake          | Beat
// ---------+-----------+--------------------+-----------------------------------------
// req_     | in        | req_valid/stall    | cmd, pixel_x/y, red, green, blue, alpha
// rsp_     | out       | rsp_valid/stall    | word_number, hit_bits, found, nearest_id, last
// csr_     | in        | psel/penable/ready | rect_x, rect_y, rect_w, rect_h, mode, count
//
// Pixel beats are taken one per cycle while not clearing or sweeping; a region hit is a
// read-modify-write of one bitmap word, with forwarding between back-to-back hits on one word.
// A finish sweeps all MAX_ENTITIES/64 bitmap words (rounded up), reading and clearing one
// per cycle unless the readout waits on the output, and then holds input off until the
// last readout word has moved to the output register.
// Region results leave one per cycle; a stalled output pauses the sweep.
// After reset a clearing pass over all bitmap words runs before the first beat.
module id_buffer_pick #(
   parameter int MAX_ENTITIES = 4096,
   parameter int COORD_BITS   = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [COORD_BITS-1:0]             req_pixel_x,
   input  logic [COORD_BITS-1:0]             req_pixel_y,
   input  logic [7:0]                        req_pixel_red,
   input  logic [7:0]                        req_pixel_green,
   input  logic [7:0]                        req_pixel_blue,
   input  logic [7:0]                        req_pixel_alpha,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ibp_pkg::WORD_NUM_W-1:0]    rsp_word_number,
   output logic [ibp_pkg::HIT_W-1:0]         rsp_hit_bits,
   output logic                              rsp_found,
   output logic [ibp_pkg::ID_W-1:0]          rsp_nearest_id,
   output logic                              rsp_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ibp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ibp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ibp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import ibp_pkg::*;

   localparam int WORDS = (MAX_ENTITIES + 63) / 64;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CNTW  = WAW + 1;
   localparam int NWW   = ECOUNT_W - 5;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_RUN   = 3'b010,
      ST_SWEEP = 3'b100
   } state_type;

   typedef struct packed {
      logic                  near;
      logic                  zero;
      logic                  last;
      logic [WORD_NUM_W-1:0] word;
   } tag_type;

   logic [COORD_BITS-1:0] rect_x;
   logic [COORD_BITS-1:0] rect_y;
   logic [COORD_BITS:0]   rect_w;
   logic [COORD_BITS:0]   rect_h;
   logic                  pick_mode;
   logic [ECOUNT_W-1:0]   entity_count;
   logic [ECOUNT_W-1:0]   valid_count;
   logic [ECOUNT_W:0]     nw_sum;
   logic [NWW-1:0]        nwords;
   logic [NWW-1:0]        nw_eff;

   logic                  req_acc;
   logic                  pix_acc;
   logic                  fin_acc;
   logic [COORD_BITS+1:0] x_end;
   logic [COORD_BITS+1:0] y_end;
   logic                  in_rect;
   logic                  keep;
   logic [ID_W-1:0]       px_id;
   logic                  id_ok;
   logic                  bm_px_valid;

   state_type             state_ff;
   state_type             state_in;
   logic [CNTW-1:0]       cnt_ff;
   logic [CNTW-1:0]       cnt_in;
   logic                  sweep_issue;
   logic                  sweep_emit;
   tag_type               tag_in;
   tag_type               tag_ff;
   logic                  tag_valid_ff;
   logic                  tag_valid_in;
   logic                  tag_move;
   logic [HIT_W-1:0]      bm_rd_data;
   logic                  near_clear;
   near_ctl_type          near_ctl;
   near_res_type          near_res;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [WORD_NUM_W-1:0] rsp_word_ff;
   logic [HIT_W-1:0]      rsp_hit_ff;
   logic                  rsp_found_ff;
   logic [ID_W-1:0]       rsp_id_ff;
   logic                  rsp_last_ff;

   ibp_csr #(
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .rect_x       (rect_x),
      .rect_y       (rect_y),
      .rect_w       (rect_w),
      .rect_h       (rect_h),
      .pick_mode    (pick_mode),
      .entity_count (entity_count)
   );

   // Usable id count and number of 64-id words it covers.
   assign valid_count = (32'(entity_count) > MAX_ENTITIES) ?
                        ECOUNT_W'(MAX_ENTITIES) : entity_count;
   assign nw_sum      = {1'b0, valid_count} + (ECOUNT_W + 1)'(63);
   assign nwords      = nw_sum[ECOUNT_W:6];
   assign nw_eff      = (nwords == '0) ? NWW'(1) : nwords;

   // Input acceptance.
   assign req_stall = (state_ff != ST_RUN);
   assign req_acc   = req_valid & ~req_stall;
   assign pix_acc   = req_acc & (req_cmd == CMD_PIXEL);
   assign fin_acc   = req_acc & (req_cmd == CMD_FINISH);

   // Pixel filter: inside the rectangle, alpha above ALPHA_NONE_MAX and not pure white.
   assign x_end   = {2'b00, rect_x} + {1'b0, rect_w};
   assign y_end   = {2'b00, rect_y} + {1'b0, rect_h};
   assign in_rect = (req_pixel_x >= rect_x) && ({2'b00, req_pixel_x} < x_end) &&
                    (req_pixel_y >= rect_y) && ({2'b00, req_pixel_y} < y_end);
   assign keep    = in_rect && (req_pixel_alpha > ALPHA_NONE_MAX) &&
                    !((req_pixel_red == 8'hFF) && (req_pixel_green == 8'hFF) &&
                      (req_pixel_blue == 8'hFF));
   assign px_id   = {req_pixel_blue, req_pixel_green, req_pixel_red};
   assign id_ok   = px_id < ID_W'(valid_count);

   assign bm_px_valid = pix_acc & keep & (pick_mode == MODE_REGION) & id_ok;
   assign near_ctl    = '{px_valid: pix_acc & keep & (pick_mode == MODE_NEAREST),
                          clear:    near_clear};

   // Sweep sequencer: reset clearing pass and finish readout.
   assign tag_move    = tag_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign sweep_issue = (state_ff == ST_CLEAR) ||
                        ((state_ff == ST_SWEEP) && (cnt_ff != CNTW'(WORDS)) &&
                         (!tag_valid_ff || tag_move));
   assign sweep_emit  = sweep_issue && (state_ff == ST_SWEEP) &&
                        (((pick_mode == MODE_REGION) && (32'(cnt_ff) < 32'(nw_eff))) ||
                         ((pick_mode == MODE_NEAREST) && (cnt_ff == '0)));

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      near_clear = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(WORDS - 1)) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (fin_acc) begin
               state_in = ST_SWEEP;
               cnt_in   = '0;
            end
         end
         ST_SWEEP: begin
            if (sweep_issue) begin
               cnt_in = cnt_ff + CNTW'(1);
            end else if ((cnt_ff == CNTW'(WORDS)) && !tag_valid_ff) begin
               state_in   = ST_RUN;
               cnt_in     = '0;
               near_clear = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Description of the word whose read data lands next cycle.
   always_comb begin
      tag_in.near = (pick_mode == MODE_NEAREST);
      tag_in.zero = (nwords == '0);
      tag_in.last = (pick_mode == MODE_NEAREST) ||
                    (32'(cnt_ff) == (32'(nw_eff) - 32'd1));
      tag_in.word = (pick_mode == MODE_NEAREST) ? '0 : WORD_NUM_W'(cnt_ff);
   end

   assign tag_valid_in = sweep_issue ? sweep_emit : (tag_move ? 1'b0 : tag_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_valid_ff <= 1'b0;
      end else begin
         tag_valid_ff <= tag_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sweep_emit) begin
         tag_ff <= tag_in;
      end
   end

   ibp_bitmap #(
      .WORDS (WORDS),
      .WAW   (WAW)
   ) u_bitmap (
      .clock    (clock),
      .reset    (reset),
      .px_valid (bm_px_valid),
      .px_addr  (px_id[6 +: WAW]),
      .px_bit   (px_id[BIT_IDX_W-1:0]),
      .sw_issue (sweep_issue),
      .sw_addr  (cnt_ff[WAW-1:0]),
      .rd_data  (bm_rd_data)
   );

   ibp_nearest #(
      .COORD_BITS (COORD_BITS)
   ) u_nearest (
      .clock       (clock),
      .reset       (reset),
      .ctl         (near_ctl),
      .px_x        (req_pixel_x),
      .px_y        (req_pixel_y),
      .px_id       (px_id),
      .rect_x      (rect_x),
      .rect_y      (rect_y),
      .rect_w      (rect_w),
      .rect_h      (rect_h),
      .valid_count (valid_count),
      .res         (near_res)
   );

   // Output register.
   assign rsp_valid_in = tag_move | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tag_move) begin
         rsp_word_ff  <= tag_ff.word;
         rsp_hit_ff   <= (tag_ff.near || tag_ff.zero) ? '0 : bm_rd_data;
         rsp_found_ff <= tag_ff.near ? near_res.found : 1'b0;
         rsp_id_ff    <= tag_ff.near ? near_res.id : '0;
         rsp_last_ff  <= tag_ff.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word_number = rsp_word_ff;
   assign rsp_hit_bits    = rsp_hit_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_nearest_id  = rsp_id_ff;
   assign rsp_last        = rsp_last_ff;

   // A pending readout word exists only during a finish sweep.
   a_tag_in_sweep: assert property (@(posedge clock) disable iff (reset)
      tag_valid_ff |-> (state_ff == ST_SWEEP))
      else $error("readout word pending outside a sweep");

   // Nothing is read out after the final beat of a finish.
   a_nothing_after_last: assert property (@(posedge clock) disable iff (reset)
      (tag_move && tag_ff.last) |=> !tag_valid_ff)
      else $error("readout continued past the final beat");

endmodule

// File: hdl/ibp_csr.sv
module ibp_csr #(
   parameter int COORD_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ibp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ibp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ibp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [COORD_BITS-1:0]            rect_x,
   output logic [COORD_BITS-1:0]            rect_y,
   output logic [COORD_BITS:0]              rect_w,
   output logic [COORD_BITS:0]              rect_h,
   output logic                             pick_mode,
   output logic [ibp_pkg::ECOUNT_W-1:0]     entity_count
);
   import ibp_pkg::*;

   logic [COORD_BITS-1:0] rect_x_ff;
   logic [COORD_BITS-1:0] rect_y_ff;
   logic [COORD_BITS:0]   rect_w_ff;
   logic [COORD_BITS:0]   rect_h_ff;
   logic                  pick_mode_ff;
   logic [ECOUNT_W-1:0]   entity_count_ff;
   csr_idx_type           reg_idx;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_idx_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register writes; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         rect_x_ff       <= '0;
         rect_y_ff       <= '0;
         rect_w_ff       <= '0;
         rect_h_ff       <= '0;
         pick_mode_ff    <= MODE_REGION;
         entity_count_ff <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            CSR_RECT_X:       rect_x_ff       <= csr_pwdata[COORD_BITS-1:0];
            CSR_RECT_Y:       rect_y_ff       <= csr_pwdata[COORD_BITS-1:0];
            CSR_RECT_W:       rect_w_ff       <= csr_pwdata[COORD_BITS:0];
            CSR_RECT_H:       rect_h_ff       <= csr_pwdata[COORD_BITS:0];
            CSR_PICK_MODE:    pick_mode_ff    <= csr_pwdata[0];
            CSR_ENTITY_COUNT: entity_count_ff <= csr_pwdata[ECOUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Read mux.
   always_comb begin
      case (reg_idx)
         CSR_RECT_X:       csr_prdata = CSR_DATA_W'(rect_x_ff);
         CSR_RECT_Y:       csr_prdata = CSR_DATA_W'(rect_y_ff);
         CSR_RECT_W:       csr_prdata = CSR_DATA_W'(rect_w_ff);
         CSR_RECT_H:       csr_prdata = CSR_DATA_W'(rect_h_ff);
         CSR_PICK_MODE:    csr_prdata = CSR_DATA_W'(pick_mode_ff);
         CSR_ENTITY_COUNT: csr_prdata = CSR_DATA_W'(entity_count_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign rect_x       = rect_x_ff;
   assign rect_y       = rect_y_ff;
   assign rect_w       = rect_w_ff;
   assign rect_h       = rect_h_ff;
   assign pick_mode    = pick_mode_ff;
   assign entity_count = entity_count_ff;

endmodule

// File: hdl/ibp_bitmap.sv
module ibp_bitmap #(
   parameter int WORDS = 64,
   parameter int WAW   = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            px_valid,
   input  logic [WAW-1:0]                  px_addr,
   input  logic [ibp_pkg::BIT_IDX_W-1:0]   px_bit,
   input  logic                            sw_issue,
   input  logic [WAW-1:0]                  sw_addr,
   output logic [ibp_pkg::HIT_W-1:0]       rd_data
);
   import ibp_pkg::*;

   logic [HIT_W-1:0]     mem [WORDS];
   logic [HIT_W-1:0]     rd_ff;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [WAW-1:0]       s1_addr_ff;
   logic [BIT_IDX_W-1:0] s1_bit_ff;
   logic                 s1_fwd_ff;
   logic                 s1_fwd_in;
   logic [HIT_W-1:0]     fwd_data_ff;
   logic [HIT_W-1:0]     merged;
   logic                 rd_en;
   logic [WAW-1:0]       rd_addr;
   logic                 wr_en;
   logic [WAW-1:0]       wr_addr;
   logic [HIT_W-1:0]     wr_data;

   // A pixel reads its word on accept and writes it back in the next cycle.
   // The sweep reads a word and clears it in the same cycle.
   assign rd_en   = px_valid | sw_issue;
   assign rd_addr = sw_issue ? sw_addr : px_addr;

   // Back-to-back hits on one word take the word just written.
   assign s1_valid_in = px_valid;
   assign s1_fwd_in   = px_valid & s1_valid_ff & (s1_addr_ff == px_addr);
   assign merged      = (s1_fwd_ff ? fwd_data_ff : rd_ff) | (HIT_W'(1) << s1_bit_ff);

   assign wr_en   = s1_valid_ff | sw_issue;
   assign wr_addr = sw_issue ? sw_addr : s1_addr_ff;
   assign wr_data = sw_issue ? '0 : merged;

   // Bitmap memory, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Modify stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (px_valid) begin
         s1_addr_ff <= px_addr;
         s1_bit_ff  <= px_bit;
         s1_fwd_ff  <= s1_fwd_in;
      end
      if (s1_valid_ff) begin
         fwd_data_ff <= merged;
      end
   end

   assign rd_data = rd_ff;

   // A pixel write-back never meets a clearing write.
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !sw_issue)
      else $error("bitmap write-back collides with sweep clear");

endmodule

// File: hdl/ibp_nearest.sv
module ibp_nearest #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ibp_pkg::near_ctl_type         ctl,
   input  logic [COORD_BITS-1:0]         px_x,
   input  logic [COORD_BITS-1:0]         px_y,
   input  logic [ibp_pkg::ID_W-1:0]      px_id,
   input  logic [COORD_BITS-1:0]         rect_x,
   input  logic [COORD_BITS-1:0]         rect_y,
   input  logic [COORD_BITS:0]           rect_w,
   input  logic [COORD_BITS:0]           rect_h,
   input  logic [ibp_pkg::ECOUNT_W-1:0]  valid_count,
   output ibp_pkg::near_res_type         res
);
   import ibp_pkg::*;

   localparam int DXW    = COORD_BITS + 2;
   localparam int SQW    = 2 * COORD_BITS + 2;
   localparam int DW     = SQW + 1;
   localparam int DTW    = (DW > 32) ? 32 : DW;
   localparam int CMPW   = (DTW > 25) ? DTW : 25;
   localparam int BDW    = 25;

   logic [COORD_BITS:0]     cx;
   logic [COORD_BITS:0]     cy;
   logic signed [DXW-1:0]   dx_in;
   logic signed [DXW-1:0]   dy_in;
   logic                    v0_ff;
   logic signed [DXW-1:0]   dx_ff;
   logic signed [DXW-1:0]   dy_ff;
   logic [ID_W-1:0]         id0_ff;
   logic signed [2*DXW-1:0] prod_x;
   logic signed [2*DXW-1:0] prod_y;
   logic                    v1_ff;
   logic [SQW-1:0]          sqx_ff;
   logic [SQW-1:0]          sqy_ff;
   logic [ID_W-1:0]         id1_ff;
   logic [DW-1:0]           dsum;
   logic [CMPW-1:0]         dcmp;
   logic                    better;
   logic                    have_best_ff;
   logic [ID_W-1:0]         best_id_ff;
   logic [BDW-1:0]          best_dist_ff;
   logic                    found;

   // Rectangle centre and signed offsets.
   assign cx    = {1'b0, rect_x} + (COORD_BITS + 1)'(rect_w >> 1);
   assign cy    = {1'b0, rect_y} + (COORD_BITS + 1)'(rect_h >> 1);
   assign dx_in = $signed({2'b00, px_x}) - $signed({1'b0, cx});
   assign dy_in = $signed({2'b00, px_y}) - $signed({1'b0, cy});

   // Squares, then sum and compare against the running best.
   assign prod_x = dx_ff * dx_ff;
   assign prod_y = dy_ff * dy_ff;
   assign dsum   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign dcmp   = CMPW'(dsum);
   assign better = !have_best_ff || (dcmp < CMPW'(best_dist_ff));

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= ctl.px_valid;
         v1_ff <= v0_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      id0_ff <= px_id;
      sqx_ff <= prod_x[SQW-1:0];
      sqy_ff <= prod_y[SQW-1:0];
      id1_ff <= id0_ff;
   end

   // Best so far; an equal distance keeps the earlier pixel.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         have_best_ff <= 1'b0;
         best_id_ff   <= '0;
         best_dist_ff <= '0;
      end else if (v1_ff && better) begin
         have_best_ff <= 1'b1;
         best_id_ff   <= id1_ff;
         best_dist_ff <= dcmp[BDW-1:0];
      end
   end

   assign found     = have_best_ff && (best_id_ff < ID_W'(valid_count));
   assign res.found = found;
   assign res.id    = found ? best_id_ff : '0;

   // Within one query the kept distance only shrinks.
   a_dist_monotonic: assert property (@(posedge clock) disable iff (reset)
      (have_best_ff && $past(have_best_ff)) |-> (best_dist_ff <= $past(best_dist_ff)))
      else $error("nearest distance grew within a query");

endmodule
